// ----- sv/sga_pkg.sv -----
// Shared types and constants for the softened gravity accumulator.
package sga_pkg;

	localparam int POS_FRAC_BITS_DEF = 24;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int EPS_W = 48;
	localparam logic [EPS_W-1:0] SOFTENING_RESET = 48'd1;

	// Input beat
	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] source_x;
		logic signed [31:0] source_y;
		logic signed [31:0] source_z;
		logic [31:0] source_mass;
		logic first;
		logic last;
	} sga_in_t;

	// Result beat
	typedef struct packed {
		logic signed [63:0] accel_x;
		logic signed [63:0] accel_y;
		logic signed [63:0] accel_z;
		logic signed [63:0] potential;
		logic saturated;
	} sga_out_t;

	// Classified work item held in the queue between front and back
	typedef struct packed {
		logic [31:0] mag_x;
		logic [31:0] mag_y;
		logic [31:0] mag_z;
		logic neg_x;
		logic neg_y;
		logic neg_z;
		logic [31:0] mass;
		logic first;
		logic last;
	} sga_job_t;

endpackage

// ----- sv/softened_gravity_accumulator_core.sv -----
// Top level of the Plummer-softened direct-summation gravity accumulator.
// Each input beat adds one source's softened force and potential to Q32.32 sums that saturate
// and set a sticky flag; 'first' clears the sums, 'last' emits them as one result beat. The
// front end accepts beats into a short queue; the back end works one job at a time through a
// bit-serial divider (quotient of 65+L bits, L = max(2*POS_FRAC_BITS, 48)), a digit-by-digit
// square root (root of ceil((65+L)/2) bits) and a shift-add multiplier run five times; a job
// whose softened distance is zero skips all three and adds nothing. softening_sq resets to 1
// and should be written only while idle.
module softened_gravity_accumulator_core import sga_pkg::*; #(
	parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sga_in_t          in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output sga_out_t         out_data,
	input  logic             cfg_we,
	input  logic [EPS_W-1:0] cfg_wdata
);

	logic [EPS_W-1:0] softening_sq_q;
	logic q_full, q_push, q_valid, q_pop;
	sga_job_t q_wdata, q_rdata;

	// softening register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			softening_sq_q <= SOFTENING_RESET;
		end else if (cfg_we) begin
			softening_sq_q <= cfg_wdata;
		end
	end

	sga_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	sga_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.valid     (q_valid),
		.pop       (q_pop),
		.pop_data  (q_rdata)
	);

	sga_back #(
		.POS_FRAC_BITS (POS_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.softening_sq (softening_sq_q),
		.q_valid      (q_valid),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

endmodule

// ----- sv/sga_front.sv -----
// Front end: accepts input beats, forms separation sign and magnitude, queues the job.
module sga_front import sga_pkg::*; (
	input  logic     in_valid,
	output logic     in_ready,
	input  sga_in_t  in_data,
	input  logic     q_full,
	output logic     q_push,
	output sga_job_t q_data
);

	// source minus target, split into sign and magnitude (magnitude fits 32 bits)
	function automatic logic [32:0] sep(logic [31:0] src, logic [31:0] tgt);
		logic [32:0] d;
		logic [32:0] nd;
		d = {src[31], src} - {tgt[31], tgt};
		nd = -d;
		return {d[32], (d[32] ? nd[31:0] : d[31:0])};
	endfunction

	logic [32:0] sx, sy, sz;

	assign sx = sep(in_data.source_x, in_data.target_x);
	assign sy = sep(in_data.source_y, in_data.target_y);
	assign sz = sep(in_data.source_z, in_data.target_z);

	assign in_ready = !q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		q_data.neg_x = sx[32];
		q_data.mag_x = sx[31:0];
		q_data.neg_y = sy[32];
		q_data.mag_y = sy[31:0];
		q_data.neg_z = sz[32];
		q_data.mag_z = sz[31:0];
		q_data.mass = in_data.source_mass;
		q_data.first = in_data.first;
		q_data.last = in_data.last;
	end

endmodule

// ----- sv/sga_fifo.sv -----
// Short job queue decoupling the front end from the back end.
module sga_fifo import sga_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  sga_job_t push_data,
	output logic     full,
	output logic     valid,
	input  logic     pop,
	output sga_job_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sga_job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign valid = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && valid;
	assign pop_data = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/sga_back.sv -----
// Back end: sequenced divide, square root, serial multiply and saturating accumulation.
module sga_back import sga_pkg::*; #(
	parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [EPS_W-1:0] softening_sq,
	input  logic             q_valid,
	input  sga_job_t         q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output sga_out_t         out_data
);

	localparam int SUM_LSB = (2 * POS_FRAC_BITS > EPS_W) ? 2 * POS_FRAC_BITS : EPS_W;
	localparam int SHL_R2 = SUM_LSB - 2 * POS_FRAC_BITS;
	localparam int SHL_EPS = SUM_LSB - EPS_W;
	localparam int R2_W = 66;
	localparam int S_W = R2_W + 1 + SHL_R2;
	localparam int Q_W = 65 + SUM_LSB;
	localparam int R_W = (Q_W + 1) / 2;
	localparam int MB_W = 64;
	localparam int P_W = Q_W + MB_W;
	localparam int ACC_SH = 32 + POS_FRAC_BITS;
	localparam int CNT_W = $clog2(Q_W + 1);
	localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PROD, ST_DIV, ST_SQRT, ST_MUL, ST_ACC, ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		JOB_R3, JOB_AX, JOB_AY, JOB_AZ, JOB_POT
	} mjob_t;

	// saturating add in offset binary; returns {clip, sum}
	function automatic logic [64:0] sat_add(logic [63:0] acc, logic neg, logic [63:0] mag,
			logic huge);
		logic [63:0] ua;
		logic [64:0] sum;
		logic [63:0] r;
		logic c;
		ua = acc ^ SIGN64;
		sum = {1'b0, ua} + {1'b0, mag};
		c = 1'b0;
		if (huge) begin
			r = neg ? '0 : '1;
			c = 1'b1;
		end else if (!neg) begin
			if (sum[64]) begin
				r = '1;
				c = 1'b1;
			end else begin
				r = sum[63:0];
			end
		end else if (mag > ua) begin
			r = '0;
			c = 1'b1;
		end else begin
			r = ua - mag;
		end
		return {c, r ^ SIGN64};
	endfunction

	state_t state_q;
	mjob_t mjob_q;
	sga_job_t job_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0] prod_s1;
	logic [R2_W-1:0] r2_q;
	logic [63:0] mm_x_q, mm_y_q, mm_z_q;
	logic [S_W-1:0] s_q, rem_q;
	logic [Q_W-1:0] quo_q;
	logic [2*R_W-1:0] rad_q;
	logic [R_W-1:0] srem_q, root_q, rinv_q;
	logic [Q_W-1:0] ma_q;
	logic [MB_W-1:0] mb_q;
	logic [P_W-1:0] mp_q;
	logic [63:0] sum_x_q, sum_y_q, sum_z_q, sum_pot_q;
	logic clip_q;

	// short multiplier for squares and mass products
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_w;

	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin mul_a = job_q.mag_x; mul_b = job_q.mag_x; end
			3'd1: begin mul_a = job_q.mag_y; mul_b = job_q.mag_y; end
			3'd2: begin mul_a = job_q.mag_z; mul_b = job_q.mag_z; end
			3'd3: begin mul_a = job_q.mass; mul_b = job_q.mag_x; end
			3'd4: begin mul_a = job_q.mass; mul_b = job_q.mag_y; end
			3'd5: begin mul_a = job_q.mass; mul_b = job_q.mag_z; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod_w = {32'b0, mul_a} * {32'b0, mul_b};

	// softened squared distance at the common LSB
	logic [S_W-1:0] s_w;
	assign s_w = (S_W'(r2_q) << SHL_R2) + (S_W'(softening_sq) << SHL_EPS);

	// restoring divide step for 2^(64+L) / s
	logic [S_W:0] div_sh, div_rn;
	logic div_ge;
	logic [Q_W-1:0] quo_n;
	assign div_sh = {rem_q, (cnt_q == '0)};
	assign div_ge = (div_sh >= {1'b0, s_q});
	assign div_rn = div_ge ? div_sh - {1'b0, s_q} : div_sh;
	assign quo_n = {quo_q[Q_W-2:0], div_ge};

	// digit-by-digit square root step
	logic [R_W+1:0] sq_t, sq_trial, sq_rn;
	logic sq_ge;
	logic [R_W-1:0] root_n;
	assign sq_t = {srem_q, rad_q[2*R_W-1 -: 2]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge = (sq_t >= sq_trial);
	assign sq_rn = sq_ge ? sq_t - sq_trial : sq_t;
	assign root_n = {root_q[R_W-2:0], sq_ge};

	// shift-add multiply step, one multiplier bit per cycle
	logic [Q_W:0] mul_sum;
	logic [P_W-1:0] mp_n;
	assign mul_sum = {1'b0, mp_q[P_W-1:MB_W]} + (mb_q[0] ? {1'b0, ma_q} : '0);
	assign mp_n = {mul_sum, mp_q[MB_W-1:1]};

	// accumulate the finished product into the selected sum
	logic [63:0] acc_cur, acc_term;
	logic acc_neg, acc_huge;
	logic [64:0] acc_res;

	always_comb begin
		acc_term = mp_q[ACC_SH +: 64];
		acc_huge = |mp_q[P_W-1:ACC_SH+64];
		case (mjob_q)
			JOB_AX: begin acc_cur = sum_x_q; acc_neg = job_q.neg_x; end
			JOB_AY: begin acc_cur = sum_y_q; acc_neg = job_q.neg_y; end
			JOB_AZ: begin acc_cur = sum_z_q; acc_neg = job_q.neg_z; end
			JOB_POT: begin
				acc_cur = sum_pot_q;
				acc_neg = 1'b1;
				acc_term = mp_q[32 +: 64];
				acc_huge = 1'b0;
			end
			default: begin acc_cur = sum_x_q; acc_neg = 1'b0; end
		endcase
		acc_res = sat_add(acc_cur, acc_neg, acc_term, acc_huge);
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	// sequencer, datapath registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mjob_q <= JOB_R3;
			cnt_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			sum_pot_q <= '0;
			clip_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one is loaded this cycle
			if (out_valid && out_ready && !(state_q == ST_EMIT && job_q.last)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						job_q <= q_data;
						r2_q <= '0;
						cnt_q <= '0;
						if (q_data.first) begin
							sum_x_q <= '0;
							sum_y_q <= '0;
							sum_z_q <= '0;
							sum_pot_q <= '0;
							clip_q <= 1'b0;
						end
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					prod_s1 <= prod_w;
					case (cnt_q[2:0])
						3'd1, 3'd2, 3'd3: r2_q <= r2_q + R2_W'(prod_s1);
						3'd4: mm_x_q <= prod_s1;
						3'd5: mm_y_q <= prod_s1;
						3'd6: mm_z_q <= prod_s1;
						default: ;
					endcase
					if (cnt_q == CNT_W'(6)) begin
						cnt_q <= '0;
						s_q <= s_w;
						rem_q <= '0;
						quo_q <= '0;
						state_q <= (s_w == '0) ? ST_EMIT : ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					rem_q <= div_rn[S_W-1:0];
					quo_q <= quo_n;
					if (cnt_q == CNT_W'(Q_W - 1)) begin
						cnt_q <= '0;
						rad_q <= (2*R_W)'(quo_n);
						root_q <= '0;
						srem_q <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					srem_q <= sq_rn[R_W-1:0];
					root_q <= root_n;
					rad_q <= {rad_q[2*R_W-3:0], 2'b00};
					if (cnt_q == CNT_W'(R_W - 1)) begin
						cnt_q <= '0;
						rinv_q <= root_n;
						ma_q <= quo_q;
						mb_q <= MB_W'(root_n);
						mp_q <= '0;
						mjob_q <= JOB_R3;
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					mp_q <= mp_n;
					mb_q <= {1'b0, mb_q[MB_W-1:1]};
					if (cnt_q == CNT_W'(MB_W - 1)) begin
						cnt_q <= '0;
						state_q <= ST_ACC;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ACC: begin
					mp_q <= '0;
					state_q <= ST_MUL;
					case (mjob_q)
						JOB_R3: begin
							ma_q <= mp_q[MB_W +: Q_W];
							mb_q <= mm_x_q;
							mjob_q <= JOB_AX;
						end
						JOB_AX: begin
							sum_x_q <= acc_res[63:0];
							clip_q <= clip_q | acc_res[64];
							mb_q <= mm_y_q;
							mjob_q <= JOB_AY;
						end
						JOB_AY: begin
							sum_y_q <= acc_res[63:0];
							clip_q <= clip_q | acc_res[64];
							mb_q <= mm_z_q;
							mjob_q <= JOB_AZ;
						end
						JOB_AZ: begin
							sum_z_q <= acc_res[63:0];
							clip_q <= clip_q | acc_res[64];
							ma_q <= Q_W'(rinv_q);
							mb_q <= MB_W'(job_q.mass);
							mjob_q <= JOB_POT;
						end
						JOB_POT: begin
							sum_pot_q <= acc_res[63:0];
							clip_q <= clip_q | acc_res[64];
							state_q <= ST_EMIT;
						end
						default: state_q <= ST_EMIT;
					endcase
				end
				ST_EMIT: begin
					if (!job_q.last) begin
						state_q <= ST_IDLE;
					end else if (!out_valid || out_ready) begin
						out_data.accel_x <= sum_x_q;
						out_data.accel_y <= sum_y_q;
						out_data.accel_z <= sum_z_q;
						out_data.potential <= sum_pot_q;
						out_data.saturated <= clip_q;
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
